// File: src/pee_pkg.sv
// postfix expression evaluator: shared types and constants
// stack geometry, character codes, status codes and arithmetic unit request
// no dependencies
`default_nettype none

package pee_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int DATA_W      = 32;
	localparam int SYM_W       = 8;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int STEP_W      = $clog2(DATA_W);

	localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
	localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_INVALID  = 3'd2,
		ST_DIVZERO  = 3'd3,
		ST_BADOP    = 3'd4,
		ST_OVERFLOW = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

endpackage

`default_nettype wire

// File: src/pee_alu.sv
// postfix expression evaluator: shared arithmetic unit
// add, subtract and multiply with a registered result, signed divide bit by bit
// depends on pee_pkg
`default_nettype none

module pee_alu (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire pee_pkg::alu_req_t          req,
	input  wire logic [pee_pkg::DATA_W-1:0] a,
	input  wire logic [pee_pkg::DATA_W-1:0] b,
	output logic                            done,
	output logic [pee_pkg::DATA_W-1:0]      result
);
	import pee_pkg::*;

	typedef enum logic [1:0] {
		A_IDLE,
		A_DIV,
		A_FIX
	} astate_t;

	astate_t             state_q;
	logic                done_q;
	logic [DATA_W-1:0]   result_q;
	logic [DATA_W:0]     rem_q;
	logic [DATA_W-1:0]   quo_q;
	logic [DATA_W-1:0]   dvs_q;
	logic                neg_q;
	logic [STEP_W-1:0]   step_q;

	logic [DATA_W-1:0]   mag_a;
	logic [DATA_W-1:0]   mag_b;
	logic [DATA_W-1:0]   prod;
	logic [DATA_W:0]     rem_sh;
	logic [DATA_W+1:0]   diff;

	always_comb begin
		mag_a  = a[DATA_W-1] ? (DATA_W'(0) - a) : a;
		mag_b  = b[DATA_W-1] ? (DATA_W'(0) - b) : b;
		prod   = DATA_W'(a * b);
		rem_sh = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= ((state_q == A_IDLE) && req.start && (req.op != ALU_DIV))
				|| (state_q == A_FIX);
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						unique case (req.op)
							ALU_ADD: begin
								result_q <= a + b;
							end
							ALU_SUB: begin
								result_q <= a - b;
							end
							ALU_MUL: begin
								result_q <= prod;
							end
							ALU_DIV: begin
								rem_q   <= '0;
								quo_q   <= mag_a;
								dvs_q   <= mag_b;
								neg_q   <= a[DATA_W-1] ^ b[DATA_W-1];
								step_q  <= STEP_W'(DATA_W - 1);
								state_q <= A_DIV;
							end
						endcase
					end
				end
				A_DIV: begin
					if (diff[DATA_W+1]) begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[DATA_W-2:0], 1'b0};
					end else begin
						rem_q <= diff[DATA_W:0];
						quo_q <= {quo_q[DATA_W-2:0], 1'b1};
					end
					if (step_q == '0) begin
						state_q <= A_FIX;
					end
					step_q <= step_q - STEP_W'(1);
				end
				A_FIX: begin
					result_q <= neg_q ? (DATA_W'(0) - quo_q) : quo_q;
					state_q  <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// File: src/postfix_expression_evaluator.sv
// postfix expression evaluator: top level with operand stack and sequencer
// depends on pee_pkg and pee_alu
//
// input channel: symbol and end_mark under in_valid / in_stall; one
// character per item, an item with end_mark set closes the expression.
// output channel: status, value and bad_symbol under out_valid / out_stall;
// exactly one item leaves for each end marker, none for characters.
// a digit, an ignored character, a character rejected at once and an end
// marker are taken in S_IDLE; an operator passes S_RD_A, S_EXEC and, but
// for a divide by zero, S_WAIT, with in_stall high until S_IDLE again.
// operators take two stack reads through the single registered read port,
// then the shared arithmetic unit: a registered result for + - *, 32
// quotient bits plus a sign fix for /, then the result is written back.
// out_valid rises in the cycle after an end marker is taken.
// the result waits in an output register; while it is stalled, characters
// are still taken, and only a further end marker is held off.
// reset clears the stack count, the latched error and the output valid;
// stack entries hold no reset value and are only used after a write.
`default_nettype none

module postfix_expression_evaluator (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [pee_pkg::SYM_W-1:0]  symbol,
	input  wire logic                       end_mark,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [2:0]                      status,
	output logic [pee_pkg::DATA_W-1:0]      value,
	output logic [pee_pkg::SYM_W-1:0]       bad_symbol
);
	import pee_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD_A,
		S_EXEC,
		S_WAIT
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	status_t             err_q;
	logic [SYM_W-1:0]    err_sym_q;
	logic                seen_q;
	alu_op_t             op_q;
	logic [DATA_W-1:0]   b_q;
	logic [DATA_W-1:0]   bottom_q;
	logic [DATA_W-1:0]   rd_data_q;
	logic [DATA_W-1:0]   mem [STACK_DEPTH];

	logic                out_valid_q;
	status_t             status_q;
	logic [DATA_W-1:0]   value_q;
	logic [SYM_W-1:0]    bad_q;

	logic                accept;
	logic                is_digit;
	logic                known_op;
	alu_op_t             dec_op;
	logic [SYM_W-1:0]    digit;
	logic [CNT_W-1:0]    cnt_m1;
	logic [CNT_W-1:0]    cnt_m2;
	logic [ADDR_W-1:0]   rd_addr;
	logic                we;
	logic [ADDR_W-1:0]   wa;
	logic [DATA_W-1:0]   wd;
	alu_req_t            alu_req;
	logic                alu_done;
	logic [DATA_W-1:0]   alu_result;

	assign in_stall = (state_q != S_IDLE) | (out_valid_q & out_stall & end_mark);
	assign accept   = in_valid & ~in_stall;

	always_comb begin
		is_digit = (symbol >= CH_ZERO) && (symbol <= CH_NINE);
		digit    = symbol - CH_ZERO;
		cnt_m1   = count_q - CNT_W'(1);
		cnt_m2   = count_q - CNT_W'(2);
		known_op = 1'b1;
		dec_op   = ALU_ADD;
		priority if (symbol == CH_PLUS) begin
			dec_op = ALU_ADD;
		end else if (symbol == CH_MINUS) begin
			dec_op = ALU_SUB;
		end else if (symbol == CH_STAR) begin
			dec_op = ALU_MUL;
		end else if (symbol == CH_SLASH) begin
			dec_op = ALU_DIV;
		end else begin
			known_op = 1'b0;
		end
		rd_addr = (state_q == S_IDLE) ? cnt_m1[ADDR_W-1:0] : cnt_m2[ADDR_W-1:0];
		alu_req.start = (state_q == S_EXEC) && !((op_q == ALU_DIV) && (b_q == '0));
		alu_req.op    = op_q;
		we = 1'b0;
		wa = count_q[ADDR_W-1:0];
		wd = DATA_W'(digit);
		if (state_q == S_IDLE) begin
			we = accept && !end_mark && (err_q == ST_OK) && is_digit
				&& (count_q < CNT_W'(STACK_DEPTH));
		end else if (state_q == S_WAIT) begin
			we = alu_done;
			wa = cnt_m2[ADDR_W-1:0];
			wd = alu_result;
		end
	end

	// operand stack, one write and one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
			if (wa == '0) begin
				bottom_q <= wd;
			end
		end
		rd_data_q <= mem[rd_addr];
	end

	pee_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (rd_data_q),
		.b      (b_q),
		.done   (alu_done),
		.result (alu_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			err_q       <= ST_OK;
			err_sym_q   <= '0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && end_mark) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && end_mark) begin
						value_q     <= '0;
						bad_q       <= '0;
						if (!seen_q) begin
							status_q <= ST_EMPTY;
						end else if (err_q != ST_OK) begin
							status_q <= err_q;
							if (err_q == ST_BADOP) begin
								bad_q <= err_sym_q;
							end
						end else if (count_q != CNT_W'(1)) begin
							status_q <= ST_INVALID;
						end else begin
							status_q <= ST_OK;
							value_q  <= bottom_q;
						end
						count_q   <= '0;
						err_q     <= ST_OK;
						err_sym_q <= '0;
						seen_q    <= 1'b0;
					end else if (accept) begin
						seen_q <= 1'b1;
						if (err_q == ST_OK) begin
							if (is_digit) begin
								if (count_q >= CNT_W'(STACK_DEPTH)) begin
									err_q <= ST_OVERFLOW;
								end else begin
									count_q <= count_q + CNT_W'(1);
								end
							end else if (count_q < CNT_W'(2)) begin
								err_q <= ST_INVALID;
							end else if (!known_op) begin
								err_q     <= ST_BADOP;
								err_sym_q <= symbol;
							end else begin
								op_q    <= dec_op;
								state_q <= S_RD_A;
							end
						end
					end
				end
				S_RD_A: begin
					b_q     <= rd_data_q;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if ((op_q == ALU_DIV) && (b_q == '0)) begin
						err_q   <= ST_DIVZERO;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (alu_done) begin
						count_q <= cnt_m1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign value      = value_q;
	assign bad_symbol = bad_q;

endmodule

`default_nettype wire

// File: sim/tb_postfix_expression_evaluator.sv
// testbench for postfix_expression_evaluator: directed rows, then random postfix
// expressions, each result checked against a cycle-free model of the evaluator
// depends on pee_pkg and postfix_expression_evaluator
`default_nettype none

module tb_postfix_expression_evaluator;
	timeunit 1ns;
	timeprecision 1ps;

	import pee_pkg::*;

	localparam int STUCK_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 850;

	typedef logic [SYM_W-1:0] char_q_t [$];

	typedef struct {
		status_t           status;
		logic [DATA_W-1:0] value;
		logic [SYM_W-1:0]  bad;
	} answer_t;

	typedef struct {
		logic [SYM_W-1:0] sym;
		bit               endm;
		bit               typed;
		answer_t          ans;
	} plan_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	wire logic         in_stall;
	logic [SYM_W-1:0]  symbol = '0;
	logic              end_mark = 1'b0;
	wire logic         out_valid;
	logic              out_stall = 1'b0;
	wire logic [2:0]   status;
	wire logic [DATA_W-1:0] value;
	wire logic [SYM_W-1:0]  bad_symbol;

	// evaluator model state
	logic [DATA_W-1:0] operands [STACK_DEPTH];
	int                operand_cnt = 0;
	status_t           latched_err = ST_OK;
	logic [SYM_W-1:0]  latched_sym = '0;
	bit                any_symbol = 1'b0;

	answer_t   answer_q [$];
	plan_row_t plan [$];
	int        items_sent = 0;
	int        fail_count = 0;
	int        shown = 0;
	int        stall_left = 0;
	int        stuck_cycles = 0;
	bit        quiet = 1'b0;
	bit        mid_paused = 1'b0;

	postfix_expression_evaluator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.symbol     (symbol),
		.end_mark   (end_mark),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.value      (value),
		.bad_symbol (bad_symbol)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit rpn_step(input logic [SYM_W-1:0] sym, input bit endm,
			output answer_t ans);
		logic [DATA_W-1:0] a, b, r, ma, mb, q;
		ans = '{ST_OK, '0, '0};
		if (endm) begin
			if (!any_symbol)
				ans.status = ST_EMPTY;
			else if (latched_err != ST_OK) begin
				ans.status = latched_err;
				if (latched_err == ST_BADOP)
					ans.bad = latched_sym;
			end else if (operand_cnt != 1)
				ans.status = ST_INVALID;
			else
				ans.value = operands[0];
			operand_cnt = 0;
			latched_err = ST_OK;
			latched_sym = '0;
			any_symbol = 1'b0;
			return 1'b1;
		end
		any_symbol = 1'b1;
		if (latched_err != ST_OK)
			return 1'b0;
		if (sym >= CH_ZERO && sym <= CH_NINE) begin
			if (operand_cnt >= STACK_DEPTH)
				latched_err = ST_OVERFLOW;
			else begin
				operands[operand_cnt] = DATA_W'(sym - CH_ZERO);
				operand_cnt++;
			end
			return 1'b0;
		end
		// too few operands wins over an unknown character
		if (operand_cnt < 2) begin
			latched_err = ST_INVALID;
			return 1'b0;
		end
		b = operands[operand_cnt-1];
		a = operands[operand_cnt-2];
		case (sym)
			CH_PLUS:  r = a + b;
			CH_MINUS: r = a - b;
			CH_STAR:  r = a * b;
			CH_SLASH: begin
				if (b == '0) begin
					latched_err = ST_DIVZERO;
					return 1'b0;
				end
				// truncate toward zero, minimum over minus one wraps
				ma = a[DATA_W-1] ? -a : a;
				mb = b[DATA_W-1] ? -b : b;
				q = ma / mb;
				r = (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
			end
			default: begin
				latched_err = ST_BADOP;
				latched_sym = sym;
				return 1'b0;
			end
		endcase
		operand_cnt--;
		operands[operand_cnt-1] = r;
		return 1'b0;
	endfunction

	function automatic logic [SYM_W-1:0] dig(input int d);
		return SYM_W'(CH_ZERO + d);
	endfunction

	function automatic logic [SYM_W-1:0] pick_op();
		case ($urandom_range(0, 3))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	function automatic void add_row(input logic [SYM_W-1:0] sym, input bit endm,
			input bit typed = 1'b0, input status_t st = ST_OK,
			input logic [SYM_W-1:0] bad = '0);
		plan_row_t r;
		r.sym = sym;
		r.endm = endm;
		r.typed = typed;
		r.ans = '{st, '0, bad};
		plan.push_back(r);
	endfunction

	function automatic char_q_t make_expr(input int n);
		char_q_t q;
		int depth;
		int left;
		depth = 0;
		left = n;
		while (left > 0 || depth > 1) begin
			if (left > 0 && (depth < 2 || $urandom_range(0, 2) != 0)) begin
				q.push_back(dig($urandom_range(0, 9)));
				depth++;
				left--;
			end else begin
				q.push_back(pick_op());
				depth--;
			end
		end
		return q;
	endfunction

	// long multiply chains to push values through wraparound
	function automatic char_q_t make_chain();
		char_q_t q;
		if ($urandom_range(0, 1) != 0)
			q = {dig(0), dig(9), CH_MINUS};
		else
			q = {dig(9)};
		repeat ($urandom_range(3, 14)) begin
			q.push_back(dig($urandom_range(2, 9)));
			if ($urandom_range(0, 4) < 3)
				q.push_back(CH_STAR);
			else
				q.push_back(($urandom_range(0, 1) != 0) ? CH_PLUS : CH_MINUS);
		end
		if ($urandom_range(0, 2) == 0) begin
			q.push_back(dig($urandom_range(1, 9)));
			q.push_back(CH_SLASH);
		end
		return q;
	endfunction

	function automatic char_q_t mangle(input char_q_t q);
		int pos;
		pos = $urandom_range(0, q.size() - 1);
		case ($urandom_range(0, 3))
			0:       q[pos] = SYM_W'($urandom_range(0, 255));
			1:       q.delete(pos);
			2:       q.insert(pos, dig($urandom_range(0, 9)));
			default: q.push_back(pick_op());
		endcase
		return q;
	endfunction

	// 2^31 wraps to the minimum, then divided by minus one
	function automatic char_q_t min_chain(input bit to_max);
		char_q_t q;
		q.push_back(dig(8));
		repeat (9) begin
			q.push_back(dig(8));
			q.push_back(CH_STAR);
		end
		q.push_back(dig(2));
		q.push_back(CH_STAR);
		q.push_back(dig(0));
		q.push_back(dig(1));
		q.push_back(CH_MINUS);
		q.push_back(CH_SLASH);
		if (to_max) begin
			q.push_back(dig(1));
			q.push_back(CH_MINUS);
		end
		return q;
	endfunction

	task automatic send_item(input logic [SYM_W-1:0] sym, input bit endm,
			input bit typed, input answer_t typed_ans);
		int gap;
		answer_t got;
		bit made;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		symbol <= sym;
		end_mark <= endm;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		made = rpn_step(sym, endm, got);
		if (made)
			answer_q.push_back(typed ? typed_ans : got);
	endtask

	task automatic send_expr(input char_q_t q);
		answer_t blank;
		blank = '{ST_OK, '0, '0};
		foreach (q[i])
			send_item(q[i], 1'b0, 1'b0, blank);
		send_item(SYM_W'($urandom_range(0, 255)), 1'b1, 1'b0, blank);
	endtask

	task automatic drain_answers();
		in_valid <= 1'b0;
		@(posedge clk);
		while (answer_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		char_q_t chars;
		int pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty expression right after reset, end symbol ignored
		add_row(8'h41, 1'b1, 1'b1, ST_EMPTY);
		add_row(dig(0), 1'b0);
		add_row(dig(7), 1'b0);
		add_row(CH_MINUS, 1'b0);
		add_row(dig(2), 1'b0);
		add_row(CH_SLASH, 1'b0);
		add_row(dig(9), 1'b0);
		add_row(dig(9), 1'b0);
		add_row(CH_STAR, 1'b0);
		add_row(CH_PLUS, 1'b0);
		add_row(8'hFF, 1'b1);
		// underflow, later digit ignored
		add_row(dig(1), 1'b0);
		add_row(CH_PLUS, 1'b0);
		add_row(dig(5), 1'b0);
		add_row(8'h00, 1'b1, 1'b1, ST_INVALID);
		// nul is an unknown operator
		add_row(dig(1), 1'b0);
		add_row(dig(2), 1'b0);
		add_row(8'h00, 1'b0);
		add_row(8'h00, 1'b1, 1'b1, ST_BADOP, 8'h00);
		add_row(dig(7), 1'b0);
		add_row(dig(0), 1'b0);
		add_row(CH_SLASH, 1'b0);
		add_row(8'h00, 1'b1, 1'b1, ST_DIVZERO);
		// unknown character with an empty stack
		add_row(8'h41, 1'b0);
		add_row(8'hFF, 1'b1, 1'b1, ST_INVALID);
		foreach (plan[i])
			send_item(plan[i].sym, plan[i].endm, plan[i].typed, plan[i].ans);
		drain_answers();

		send_expr(min_chain(1'b0));
		send_expr(min_chain(1'b1));
		// one digit past a full stack, trailing characters ignored
		chars.delete();
		repeat (STACK_DEPTH + 1) chars.push_back(dig($urandom_range(0, 9)));
		repeat (4) chars.push_back(SYM_W'($urandom_range(0, 255)));
		send_expr(chars);
		// full stack folded back down
		chars.delete();
		repeat (STACK_DEPTH) chars.push_back(dig($urandom_range(0, 9)));
		repeat (STACK_DEPTH - 1) begin
			case ($urandom_range(0, 2))
				0:       chars.push_back(CH_PLUS);
				1:       chars.push_back(CH_MINUS);
				default: chars.push_back(CH_STAR);
			endcase
		end
		send_expr(chars);

		while (items_sent < RANDOM_ITEMS) begin
			quiet = ((items_sent / 120) % 4) == 3;
			pick = $urandom_range(0, 99);
			if (pick < 65)
				chars = make_expr(($urandom_range(0, 9) == 0) ?
					$urandom_range(7, 24) : $urandom_range(1, 6));
			else if (pick < 77)
				chars = make_chain();
			else if (pick < 89)
				chars = mangle(make_expr($urandom_range(1, 6)));
			else if (pick < 95) begin
				chars.delete();
				repeat ($urandom_range(1, 6)) chars.push_back(SYM_W'($urandom_range(0, 255)));
			end else if (pick < 98)
				chars.delete();
			else
				chars = make_expr($urandom_range(40, STACK_DEPTH));
			send_expr(chars);
			if (!mid_paused && items_sent >= RANDOM_ITEMS / 2) begin
				mid_paused = 1'b1;
				drain_answers();
			end
		end

		drain_answers();
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (answer_q.size() == 0) begin
				fail_count++;
				if (shown < 10) begin
					shown++;
					$display("%0t: unexpected result status %0d value %0d bad_symbol %02h",
						$time, status, $signed(value), bad_symbol);
				end
			end else begin
				want = answer_q.pop_front();
				if (status !== want.status || value !== want.value ||
						bad_symbol !== want.bad) begin
					fail_count++;
					if (shown < 10) begin
						shown++;
						$display("%0t: status %0d/%0d value %0d/%0d bad_symbol %02h/%02h (exp/got)",
							$time, want.status, status, $signed(want.value),
							$signed(value), want.bad, bad_symbol);
					end
				end
			end
			stall_left = quiet ? 0 : $urandom_range(0, 3);
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

endmodule

`default_nettype wire
